// File: rtl/ihexp_pkg.sv
// Shared types, codes and constants of the Intel HEX record parser.
package ihexp_pkg;

	// receive modes
	localparam logic [2:0] MODE_READY  = 3'd0;
	localparam logic [2:0] MODE_HEX    = 3'd1;
	localparam logic [2:0] MODE_BINARY = 3'd2;
	localparam logic [2:0] MODE_EOF    = 3'd3;
	localparam logic [2:0] MODE_ERROR  = 3'd4;
	localparam logic [2:0] MODE_DELAY  = 3'd5;

	// record field states
	localparam logic [3:0] FS_NONE    = 4'd0;
	localparam logic [3:0] FS_START   = 4'd1;
	localparam logic [3:0] FS_ADDR_HI = 4'd2;
	localparam logic [3:0] FS_ADDR_LO = 4'd3;
	localparam logic [3:0] FS_RECTYPE = 4'd4;
	localparam logic [3:0] FS_SEG_HI  = 4'd5;
	localparam logic [3:0] FS_SEG_LO  = 4'd6;
	localparam logic [3:0] FS_WRITE   = 4'd7;
	localparam logic [3:0] FS_END     = 4'd8;

	// event codes
	localparam logic [2:0] EV_WRITE    = 3'd0;
	localparam logic [2:0] EV_RESTART  = 3'd1;
	localparam logic [2:0] EV_FORMAT   = 3'd2;
	localparam logic [2:0] EV_HEX      = 3'd3;
	localparam logic [2:0] EV_CHECKSUM = 3'd4;
	localparam logic [2:0] EV_EOF      = 3'd5;
	localparam logic [2:0] EV_GO       = 3'd6;

	// record types
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_SEG  = 8'h02;
	localparam logic [7:0] REC_LIN  = 8'h04;

	// characters
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_IDLE    = 8'h80;
	localparam logic [7:0] CH_RESTART = 8'h52;
	localparam logic [7:0] CH_DELAY   = 8'h73;
	localparam logic [7:0] CH_GO_LC   = 8'h67;
	localparam logic [7:0] CH_GO_UC   = 8'h47;

	localparam logic [31:0] DELAY_RESET = 32'd10000;
	localparam logic [31:0] JUMP_RESET  = 32'h0008_0000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  fs;
		logic        nib_pend;
		logic        hex_bad;
		logic [3:0]  high_nib;
		logic [7:0]  bytes_left;
		logic [16:0] offset;
		logic [7:0]  kind;
		logic [31:0] seg;
		logic [7:0]  sum;
		logic [31:0] delay;
	} ihexp_state_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  event_res;
		logic [31:0] write_address;
		logic [7:0]  write_data;
		logic [31:0] launch_delay;
		logic [31:0] go_address;
	} ihexp_res_t;

	// parser state after a restart; the start delay survives
	function automatic ihexp_state_t clear_state(input logic [31:0] delay);
		ihexp_state_t s;
		s = '0;
		s.mode = MODE_READY;
		s.fs = FS_NONE;
		s.delay = delay;
		return s;
	endfunction

endpackage

// File: rtl/ihexp_if.sv
// Valid/ready channels of the parser: received bytes, results, configuration.
interface ihexp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ihexp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [31:0] write_address;
	logic [7:0]  write_data;
	logic [31:0] launch_delay;
	logic [31:0] go_address;

	modport source (output valid, output event_res, output write_address,
		output write_data, output launch_delay, output go_address, input ready);
	modport sink (input valid, input event_res, input write_address,
		input write_data, input launch_delay, input go_address, output ready);
endinterface

interface ihexp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ihexp_parse.sv
// Next-state and result logic of the parser for one received byte.
module ihexp_parse import ihexp_pkg::*; (
	input  ihexp_state_t st,
	input  logic [7:0]   rx_byte,
	input  logic [31:0]  jump_address,
	output ihexp_state_t nxt,
	output ihexp_res_t   rs
);

	logic        dv;
	logic [3:0]  dval;
	logic        rec_en;
	logic [7:0]  rv;
	logic [31:0] seg_or;

	// only '0'-'9' and 'A'-'F' count as hex digits
	always_comb begin
		dv = 1'b0;
		dval = rx_byte[3:0];
		if (rx_byte >= 8'h30 && rx_byte <= 8'h39) begin
			dv = 1'b1;
		end else if (rx_byte >= 8'h41 && rx_byte <= 8'h46) begin
			dv = 1'b1;
			dval = 4'(rx_byte - 8'h37);
		end
	end

	assign seg_or = st.seg | {24'd0, rv};

	always_comb begin
		nxt = st;
		rs = '0;
		rec_en = 1'b0;
		rv = rx_byte;

		if (st.mode == MODE_HEX && st.nib_pend) begin
			nxt.nib_pend = 1'b0;
			if (st.hex_bad || !dv) begin
				nxt.hex_bad = 1'b0;
				nxt.mode = MODE_ERROR;
				rs.valid = 1'b1;
				rs.event_res = EV_HEX;
			end else begin
				rec_en = 1'b1;
				rv = {st.high_nib, dval};
			end
		end else if (st.mode == MODE_DELAY) begin
			if (!dv) begin
				nxt.mode = MODE_EOF;
			end else begin
				nxt.delay = {st.delay[27:0], dval};
			end
		end else if (rx_byte == CH_RESTART && st.mode != MODE_BINARY) begin
			nxt = clear_state(st.delay);
			rs.valid = 1'b1;
			rs.event_res = EV_RESTART;
		end else begin
			unique case (st.mode)
				MODE_READY: begin
					if (rx_byte == CH_COLON || rx_byte == CH_EQUAL) begin
						nxt.mode = (rx_byte == CH_COLON) ? MODE_HEX : MODE_BINARY;
						nxt.fs = FS_START;
						nxt.sum = 8'd0;
						nxt.nib_pend = 1'b0;
						nxt.hex_bad = 1'b0;
					end else if (rx_byte != CH_CR && rx_byte != CH_LF
						&& rx_byte != CH_IDLE) begin
						nxt.mode = MODE_ERROR;
						rs.valid = 1'b1;
						rs.event_res = EV_FORMAT;
					end
				end
				MODE_HEX: begin
					nxt.hex_bad = !dv;
					nxt.high_nib = dv ? dval : 4'd0;
					nxt.nib_pend = 1'b1;
				end
				MODE_BINARY: begin
					rec_en = 1'b1;
				end
				MODE_EOF: begin
					if (rx_byte == CH_DELAY) begin
						nxt.delay = 32'd0;
						nxt.mode = MODE_DELAY;
					end else if (rx_byte == CH_GO_LC || rx_byte == CH_GO_UC) begin
						rs.valid = 1'b1;
						rs.event_res = EV_GO;
						rs.launch_delay = st.delay;
						rs.go_address = jump_address;
					end
				end
				default: begin
				end
			endcase
		end

		// one decoded record byte
		if (rec_en) begin
			nxt.sum = st.sum + rv;
			unique case (st.fs)
				FS_START: begin
					nxt.bytes_left = rv;
					nxt.fs = FS_ADDR_HI;
				end
				FS_ADDR_HI: begin
					nxt.offset = {1'b0, rv, 8'd0};
					nxt.fs = FS_ADDR_LO;
				end
				FS_ADDR_LO: begin
					nxt.offset = st.offset | {9'd0, rv};
					nxt.fs = FS_RECTYPE;
				end
				FS_RECTYPE: begin
					nxt.kind = rv;
					if (rv == REC_DATA) begin
						nxt.fs = (st.bytes_left != 8'd0) ? FS_WRITE : FS_END;
					end else if (rv == REC_SEG || rv == REC_LIN) begin
						nxt.fs = FS_SEG_HI;
					end else begin
						nxt.fs = FS_END;
					end
				end
				FS_WRITE: begin
					rs.valid = 1'b1;
					rs.event_res = EV_WRITE;
					rs.write_address = st.seg + {15'd0, st.offset};
					rs.write_data = rv;
					nxt.offset = st.offset + 17'd1;
					nxt.bytes_left = st.bytes_left - 8'd1;
					if (st.bytes_left == 8'd1) begin
						nxt.fs = FS_END;
					end
				end
				FS_SEG_HI: begin
					nxt.seg = {16'd0, rv, 8'd0};
					nxt.bytes_left = st.bytes_left - 8'd1;
					nxt.fs = FS_SEG_LO;
				end
				FS_SEG_LO: begin
					nxt.seg = (st.kind == REC_LIN) ? {seg_or[15:0], 16'd0}
						: {seg_or[27:0], 4'd0};
					nxt.bytes_left = st.bytes_left - 8'd1;
					nxt.fs = FS_END;
				end
				FS_END: begin
					if (st.bytes_left != 8'd0) begin
						nxt.bytes_left = st.bytes_left - 8'd1;
					end else if (nxt.sum != 8'd0) begin
						nxt.mode = MODE_ERROR;
						rs.valid = 1'b1;
						rs.event_res = EV_CHECKSUM;
					end else if (st.kind == REC_EOF) begin
						nxt.mode = MODE_EOF;
						rs.valid = 1'b1;
						rs.event_res = EV_EOF;
					end else begin
						nxt.mode = MODE_READY;
					end
				end
				default: begin
					nxt.mode = MODE_ERROR;
					rs.valid = 1'b1;
					rs.event_res = EV_FORMAT;
				end
			endcase
		end
	end

endmodule

// File: rtl/intel_hex_loader_parser_core.sv
// Intel HEX record parser core: one received byte in, at most one event out.
// Takes one received byte per clock cycle, sustained, as long as the result side
// keeps up. A byte is latched into an input register; the parser state and the
// result register are updated from it when it moves on, which a waiting result can
// hold off for a byte that makes an event. The output register lets a new byte enter
// while a finished result is still waiting; bytes that produce no event never wait
// on the result side. jump_address is written through the configuration channel
// and is reported with each go event.
module intel_hex_loader_parser_core import ihexp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	ihexp_rx_if.sink   rx,
	ihexp_res_if.source res,
	ihexp_cfg_if.sink  cfg
);

	logic         vld_s1;
	logic [7:0]   byte_s1;
	ihexp_state_t st_q;
	ihexp_state_t st_nxt;
	ihexp_res_t   pres;
	logic [31:0]  jump_q;
	logic         out_vld_q;
	ihexp_res_t   out_q;
	logic         advance;

	ihexp_parse u_parse (
		.st           (st_q),
		.rx_byte      (byte_s1),
		.jump_address (jump_q),
		.nxt          (st_nxt),
		.rs           (pres)
	);

	// the held byte moves on unless it makes an event and the output slot is busy
	assign advance = vld_s1 && (!pres.valid || !out_vld_q || res.ready);
	assign rx.ready = !vld_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q <= clear_state(DELAY_RESET);
			jump_q <= JUMP_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				vld_s1 <= rx.valid;
			end
			if (advance) begin
				st_q <= st_nxt;
			end
			if (cfg.valid) begin
				jump_q <= cfg.data;
			end
			if (advance && pres.valid) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
		if (advance && pres.valid) begin
			out_q <= pres;
		end
	end

	assign res.valid = out_vld_q;
	assign res.event_res = out_q.event_res;
	assign res.write_address = out_q.write_address;
	assign res.write_data = out_q.write_data;
	assign res.launch_delay = out_q.launch_delay;
	assign res.go_address = out_q.go_address;

	// a held byte that cannot move on stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(byte_s1))
		else $error("input register lost a stalled byte");

	// inside a record the field state is always defined
	a_fs_defined: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_HEX || st_q.mode == MODE_BINARY) |-> st_q.fs != FS_NONE)
		else $error("record mode without field state");

	// a pending first nibble exists only in hex mode
	a_nib_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.nib_pend |-> st_q.mode == MODE_HEX)
		else $error("pending nibble outside hex mode");

endmodule
